>>> hw/rtl/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg: shared definitions of the LRU tag engine
// Sizes, register indexes, the set row layout and the result layout.
// ----------------------------------------------------------------------------
package salru_pkg;

  // Built geometry.
  localparam int WAYS      = 4;
  localparam int SETS      = 64;
  localparam int ADDR_BITS = 32;

  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int NW_W   = $clog2(WAYS + 1);
  localparam int TAG_W  = ADDR_BITS;

  // Field widths fixed by the interface.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam int FIELD_MAX  = 6;
  localparam int CNT_W      = 32;
  localparam int OUT_WAY_W  = 2;
  localparam int OUT_SET_W  = 6;
  localparam int OUT_TAG_W  = 32;
  localparam int RES_W      = 1 + OUT_WAY_W + OUT_SET_W + OUT_TAG_W + 2 * CNT_W;
  localparam int RES_BYTES_W = ((RES_W + 7) / 8) * 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED   = 2'd2;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // One row of the set memory: tags, valid bits and recency order
  // (position 0 is most recent).
  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tags;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0][WAY_W-1:0] order;
  } row_t;

  // Result item, last field (hit) in the lowest bits.
  typedef struct packed {
    logic [CNT_W-1:0]     accesses;
    logic [CNT_W-1:0]     misses;
    logic [OUT_TAG_W-1:0] line_tag;
    logic [OUT_SET_W-1:0] set_index;
    logic [OUT_WAY_W-1:0] way;
    logic                 hit;
  } result_t;

endpackage

>>> hw/rtl/set_assoc_cache_lru_tags.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags: tag and true-LRU replacement engine
// Looks up a read address in a set-associative tag store and updates it.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the s_t* channel carries a 32-bit byte address. It is split
//   into offset, set index and tag by the configured bit counts. The result
//   on the m_t* channel reports hit, the way hit or filled, the set, the tag
//   and saturating miss and access counts.
//   The cfg_* channel writes offset_bits, index_bits and ways_used; it is
//   ready outside reset and must only be used while the engine is idle.
// Timing:
//   The set row (tags, valid bits, recency order) is registered from the set
//   memory at the accept; in the lookup state, once the output register is
//   free, it is compared, reordered and written back while the result is
//   registered. No new request is accepted until that lookup completes; the
//   read-modify-write of the single-port set memory sets this.
// Reset:
//   rst marks all rows invalid with identity recency order through per-row
//   flags, zeroes the counters and loads the default configuration.
// Stall:
//   A result waits in the output register; a new request is still accepted
//   and its lookup waits until the output register has been taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tags (
  input  logic                               clk,
  input  logic                               rst,
  // Address requests.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [31:0]                        s_tdata,   // address[31:0]
  // Lookup results.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // hit[0], way[2:1], set_index[8:3], line_tag[40:9], misses[72:41],
  // accesses[104:73], zero fill [111:105]
  output logic [salru_pkg::RES_BYTES_W-1:0]  m_tdata,
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [salru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int WAYS  = salru_pkg::WAYS;
  localparam int WAY_W = salru_pkg::WAY_W;
  localparam int NW_W  = salru_pkg::NW_W;
  localparam int SET_W = salru_pkg::SET_W;
  localparam int TAG_W = salru_pkg::TAG_W;
  localparam int CNT_W = salru_pkg::CNT_W;

  // Configuration registers.
  logic [2:0] offset_bits;
  logic [2:0] index_bits;
  logic [2:0] ways_used;

  // Control and request registers.
  salru_pkg::state_t state, state_next;
  logic [TAG_W-1:0]  tag_q;
  logic [SET_W-1:0]  set_q;
  logic [CNT_W-1:0]  misses;
  logic [CNT_W-1:0]  accesses;
  logic              out_valid;
  salru_pkg::result_t out_res;

  // Set memory and its per-row initialised flags.
  salru_pkg::row_t   set_mem [salru_pkg::SETS];
  logic [salru_pkg::SETS-1:0] row_init;
  salru_pkg::row_t   rd_row;
  logic              rd_init;

  // Address split and handshakes.
  logic [2:0]        ob, ib;
  logic [3:0]        shift_tag;
  logic [TAG_W-1:0]  tag_in;
  logic [SET_W-1:0]  set_in;
  logic              s_accept;
  logic              done;

  // Lookup datapath.
  salru_pkg::row_t   row_eff;
  salru_pkg::row_t   row_next;
  logic [NW_W-1:0]   nw;
  logic              hit_found, inv_found;
  logic [WAY_W-1:0]  hit_pos, inv_pos, chosen;
  logic [WAY_W-1:0]  way_sel;
  logic [CNT_W-1:0]  misses_next, accesses_next;

  assign cfg_ready = !rst;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 3'd4;
      index_bits  <= 3'd6;
      ways_used   <= 3'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        salru_pkg::REG_OFFSET_BITS: offset_bits <= cfg_data;
        salru_pkg::REG_INDEX_BITS:  index_bits  <= cfg_data;
        salru_pkg::REG_WAYS_USED:   ways_used   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Split the incoming address; field widths above the limit are clamped.
  always_comb begin
    ob        = (offset_bits > 3'(salru_pkg::FIELD_MAX)) ? 3'(salru_pkg::FIELD_MAX)
                                                         : offset_bits;
    ib        = (index_bits > 3'(salru_pkg::FIELD_MAX)) ? 3'(salru_pkg::FIELD_MAX)
                                                        : index_bits;
    shift_tag = 4'(ob) + 4'(ib);
    tag_in    = s_tdata >> shift_tag;
    set_in    = SET_W'((s_tdata >> ob) & ((32'd1 << ib) - 32'd1));
  end

  assign s_accept = s_tvalid && s_tready;

  // Controller: accept in idle, finish the lookup once the output is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= salru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    done       = 1'b0;
    unique case (state)
      salru_pkg::ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = salru_pkg::ST_LOOKUP;
        end
      end
      salru_pkg::ST_LOOKUP: begin
        if (!out_valid || m_tready) begin
          done       = 1'b1;
          state_next = salru_pkg::ST_IDLE;
        end
      end
      default: state_next = salru_pkg::ST_IDLE;
    endcase
  end

  // Hold the tag and set of the request under lookup.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      tag_q <= tag_in;
      set_q <= set_in;
    end
  end

  // Set memory: read at accept, write back when the lookup completes.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      rd_row <= set_mem[set_in];
    end
    if (done) begin
      set_mem[set_q] <= row_next;
    end
  end

  // Row flags: a row never written reads as invalid with identity order.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
      rd_init  <= 1'b0;
    end else begin
      if (s_accept) begin
        rd_init <= row_init[set_in];
      end
      if (done) begin
        row_init[set_q] <= 1'b1;
      end
    end
  end

  // Lookup: search recency positions, pick the way and reorder the row.
  always_comb begin
    row_eff = rd_row;
    if (!rd_init) begin
      row_eff.valid = '0;
      for (int p = 0; p < WAYS; p++) begin
        row_eff.order[p] = WAY_W'(p);
      end
    end

    if (ways_used == 3'd0) begin
      nw = NW_W'(1);
    end else if (ways_used > 3'(WAYS)) begin
      nw = NW_W'(WAYS);
    end else begin
      nw = NW_W'(ways_used);
    end

    hit_found = 1'b0;
    hit_pos   = '0;
    inv_found = 1'b0;
    inv_pos   = '0;
    for (int p = 0; p < WAYS; p++) begin
      if (NW_W'(p) < nw) begin
        if (!hit_found && row_eff.valid[row_eff.order[p]] &&
            row_eff.tags[row_eff.order[p]] == tag_q) begin
          hit_found = 1'b1;
          hit_pos   = WAY_W'(p);
        end
        if (!inv_found && !row_eff.valid[row_eff.order[p]]) begin
          inv_found = 1'b1;
          inv_pos   = WAY_W'(p);
        end
      end
    end

    priority if (hit_found) begin
      chosen = hit_pos;
    end else if (inv_found) begin
      chosen = inv_pos;
    end else begin
      chosen = WAY_W'(nw - NW_W'(1));
    end
    way_sel = row_eff.order[chosen];

    // Move the chosen way to the front; positions before it shift back.
    row_next = row_eff;
    for (int p = 0; p < WAYS; p++) begin
      if (p == 0) begin
        row_next.order[p] = way_sel;
      end else if (WAY_W'(p) <= chosen) begin
        row_next.order[p] = row_eff.order[p-1];
      end
    end
    if (!hit_found) begin
      row_next.tags[way_sel]  = tag_q;
      row_next.valid[way_sel] = 1'b1;
    end

    // Saturating counters.
    accesses_next = (accesses == '1) ? accesses : accesses + CNT_W'(1);
    if (!hit_found && misses != '1) begin
      misses_next = misses + CNT_W'(1);
    end else begin
      misses_next = misses;
    end
  end

  // Counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      misses   <= '0;
      accesses <= '0;
    end else if (done) begin
      misses   <= misses_next;
      accesses <= accesses_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res.hit       <= hit_found;
      out_res.way       <= salru_pkg::OUT_WAY_W'(way_sel);
      out_res.set_index <= salru_pkg::OUT_SET_W'(set_q);
      out_res.line_tag  <= salru_pkg::OUT_TAG_W'(tag_q);
      out_res.misses    <= misses_next;
      out_res.accesses  <= accesses_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = salru_pkg::RES_BYTES_W'(out_res);

endmodule

>>> hw/rtl/salru_checker.sv
// ----------------------------------------------------------------------------
// salru_checker: port-level checks of the LRU tag engine
// Watches the request, result and configuration channels over time.
// ----------------------------------------------------------------------------
module salru_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [salru_pkg::RES_BYTES_W-1:0]  m_tdata,
  input logic                               cfg_valid,
  input logic                               cfg_ready
);

  // A request occupies the engine for its lookup cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted in back-to-back cycles");

  // A fresh result is registered by the lookup that follows an accept.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a preceding request");

  // A miss is always counted.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[72:41] != 32'd0)
    else $error("miss reported with zero miss count");

  // A held result stays unchanged while stalled.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Configuration must be written only while no request or result is pending; the engine does not enforce it.
  assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !s_tvalid && !m_tvalid)
    else $error("configuration written while busy");

endmodule

bind set_assoc_cache_lru_tags salru_checker u_salru_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

>>> tb/tb_set_assoc_cache_lru_tags.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_tags: self-checking bench for the LRU tag engine
// Streams address requests through the engine under several cache shapes and
// checks every lookup result against an LRU cache predictor kept in step with
// each accepted request. Both stream sides idle at random; the result side
// holds off once for a long stretch to fill the engine.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_tags;
  timeunit 1ns;
  timeprecision 1ps;

  // No register behind this index.
  localparam logic [salru_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int PHASES     = 9;
  localparam int PHASE_REQS = 175;
  localparam int SETTLE_CYC = 4;
  localparam int LONG_HOLD  = 300;
  localparam int HOLD_AFTER = 400;
  localparam int TAIL_CYC   = 8;
  localparam int CYC_LIMIT  = 1000000;

  typedef enum logic [1:0] {
    OP_ADDR,
    OP_CFG,
    OP_DRAIN
  } req_kind_t;

  typedef struct {
    req_kind_t                        kind;
    logic [31:0]                      addr;
    int                               gap;
    logic [salru_pkg::CFG_IDX_W-1:0]  idx;
    logic [salru_pkg::CFG_DATA_W-1:0] val;
  } req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;  // address[31:0]
  logic m_tvalid;
  logic m_tready = 1'b0;
  // hit, way, set_index, line_tag, misses, accesses, zero fill
  logic [salru_pkg::RES_BYTES_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [salru_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [salru_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  set_assoc_cache_lru_tags uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Cache shape of each phase: offset bits, index bits, ways in use.
  int ph_off [0:PHASES-1] = '{4, 0, 6, 7, 2, 5, 1, 3, 3};
  int ph_idx [0:PHASES-1] = '{6, 0, 6, 7, 3, 1, 2, 4, 4};
  int ph_way [0:PHASES-1] = '{4, 0, 4, 7, 2, 3, 5, 1, 4};

  // Predicted cache contents and settings.
  logic [31:0]                 line_tags  [salru_pkg::SETS][salru_pkg::WAYS];
  bit                          line_valid [salru_pkg::SETS][salru_pkg::WAYS];
  logic [salru_pkg::WAY_W-1:0] lru_order  [salru_pkg::SETS][salru_pkg::WAYS];
  logic [31:0]      miss_total;
  logic [31:0]      access_total;
  logic [salru_pkg::CFG_DATA_W-1:0] used_offset_bits;
  logic [salru_pkg::CFG_DATA_W-1:0] used_index_bits;
  logic [salru_pkg::CFG_DATA_W-1:0] used_ways;

  salru_pkg::result_t lookup_q[$];
  req_t    req_q[$];
  int      err_cnt = 0;
  int      results_seen = 0;
  int      cyc = 0;
  logic    s_took = 1'b0;
  logic    cfg_took = 1'b0;

  // Driver and receiver bookkeeping.
  int gap_left = 0;
  bit gap_armed = 0;
  int settle_left = 0;
  bit settle_armed = 0;
  int hold_left = 0;
  bit long_hold_done = 0;
  int stall_left = 0;
  int mode_left = 0;
  bit rx_calm = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_field(input int v);
    return (v > salru_pkg::FIELD_MAX) ? salru_pkg::FIELD_MAX : v;
  endfunction

  function automatic int clamp_ways(input int v);
    if (v < 1) return 1;
    if (v > salru_pkg::WAYS) return salru_pkg::WAYS;
    return v;
  endfunction

  task automatic cache_reset();
    for (int s = 0; s < salru_pkg::SETS; s++) begin
      for (int w = 0; w < salru_pkg::WAYS; w++) begin
        line_tags[s][w]  = '0;
        line_valid[s][w] = 0;
        lru_order[s][w]  = salru_pkg::WAY_W'(w);
      end
    end
    miss_total       = '0;
    access_total     = '0;
    used_offset_bits = 3'd4;
    used_index_bits  = 3'd6;
    used_ways        = 3'd4;
  endtask

  // One read access against the predicted cache; updates it and returns
  // the result the engine should give.
  function automatic salru_pkg::result_t lru_lookup(input logic [31:0] a);
    int ob, ib, nw, s, pos, chosen;
    bit hit, found;
    logic [31:0] tg, idx_mask;
    logic [salru_pkg::WAY_W-1:0] w;
    salru_pkg::result_t r;
    ob = clamp_field(used_offset_bits);
    ib = clamp_field(used_index_bits);
    nw = clamp_ways(used_ways);
    tg = a >> (ob + ib);
    idx_mask = (32'd1 << ib) - 32'd1;
    s = int'((a >> ob) & idx_mask) % salru_pkg::SETS;
    hit = 0;
    found = 0;
    chosen = nw - 1;
    // Search the positions in use, most recent first.
    for (pos = 0; pos < nw; pos++) begin
      w = lru_order[s][pos];
      if (!hit && line_valid[s][w] && line_tags[s][w] == tg) begin
        hit = 1;
        chosen = pos;
      end
    end
    // On a miss take the first invalid position, else the least recent one.
    if (!hit) begin
      for (pos = 0; pos < nw; pos++) begin
        w = lru_order[s][pos];
        if (!found && !line_valid[s][w]) begin
          found = 1;
          chosen = pos;
        end
      end
      w = lru_order[s][chosen];
      line_tags[s][w]  = tg;
      line_valid[s][w] = 1;
      if (miss_total != 32'hFFFF_FFFF) miss_total++;
    end else begin
      w = lru_order[s][chosen];
    end
    // The chosen way becomes most recent; those in front of it move back.
    for (pos = chosen; pos > 0; pos--) lru_order[s][pos] = lru_order[s][pos-1];
    lru_order[s][0] = w;
    if (access_total != 32'hFFFF_FFFF) access_total++;
    r.hit       = hit;
    r.way       = salru_pkg::OUT_WAY_W'(w);
    r.set_index = salru_pkg::OUT_SET_W'(s);
    r.line_tag  = tg;
    r.misses    = miss_total;
    r.accesses  = access_total;
    return r;
  endfunction

  // Addresses drawn from a few sets and a few more tags than ways, so that
  // hits, fills and evictions all come often; some are fully random.
  function automatic logic [31:0] shaped_addr(input int ob, input int ib, input int nw,
                                              input logic [31:0] base);
    int r;
    logic [31:0] tg, st, off, mask;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom();
    tg = base + $urandom_range(0, nw + 2);
    if (r < 18) tg = $urandom();
    mask = (32'd1 << ib) - 32'd1;
    st = (r < 30) ? ($urandom() & mask) : ($urandom_range(0, 3) & mask);
    off = $urandom() & ((32'd1 << ob) - 32'd1);
    return (tg << (ob + ib)) | (st << ob) | off;
  endfunction

  task automatic push_addr(input logic [31:0] a, input int gap);
    req_t q;
    q.kind = OP_ADDR;
    q.addr = a;
    q.gap  = gap;
    q.idx  = '0;
    q.val  = '0;
    req_q.push_back(q);
  endtask

  task automatic push_cfg(input logic [salru_pkg::CFG_IDX_W-1:0] idx,
                          input logic [salru_pkg::CFG_DATA_W-1:0] val);
    req_t q;
    q.kind = OP_CFG;
    q.addr = '0;
    q.gap  = 0;
    q.idx  = idx;
    q.val  = val;
    req_q.push_back(q);
  endtask

  task automatic push_drain();
    req_t q;
    q.kind = OP_DRAIN;
    q.addr = '0;
    q.gap  = 0;
    q.idx  = '0;
    q.val  = '0;
    req_q.push_back(q);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("[%0t] %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
  endtask

  // Stimulus plan, reset and end of run.
  initial begin
    int ob, ib, nw;
    bit calm;
    logic [31:0] tag_base;
    cache_reset();
    calm = 0;
    tag_base = '0;

    // Default shape: offset extremes, a set filled way by way, eviction of
    // the least recent way and a hit on the least recent position.
    push_addr(32'h0000_0000, 0);
    push_addr(32'h0000_000F, 0);
    push_addr(32'hFFFF_FFFF, 0);
    push_addr(32'hFFFF_FFF0, 1);
    push_addr(32'h0000_0400, 0);
    push_addr(32'h0000_0800, 0);
    push_addr(32'h0000_0C00, 2);
    push_addr(32'h0000_1000, 0);
    push_addr(32'h0000_0400, 0);
    push_addr(32'h0000_0000, 0);
    push_addr(32'h8000_0000, 0);
    push_addr(32'h7FFF_FFFF, 0);
    push_addr(32'h5555_5555, 0);
    push_addr(32'hAAAA_AAAA, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        push_drain();
        push_cfg(salru_pkg::REG_OFFSET_BITS, salru_pkg::CFG_DATA_W'(ph_off[ph]));
        push_cfg(salru_pkg::REG_INDEX_BITS, salru_pkg::CFG_DATA_W'(ph_idx[ph]));
        push_cfg(salru_pkg::REG_WAYS_USED, salru_pkg::CFG_DATA_W'(ph_way[ph]));
        if (ph == 1) push_cfg(REG_SPARE, 3'd7);
      end
      ob = clamp_field(ph_off[ph]);
      ib = clamp_field(ph_idx[ph]);
      nw = clamp_ways(ph_way[ph]);
      // The last phase reuses the previous tags to meet lines kept while
      // only one way was in use.
      if (ph != PHASES - 1) tag_base = $urandom();
      if (ph == 1) begin
        // Whole address is the tag, single way: miss, hit, evict, miss.
        push_addr(32'h1234_5678, 0);
        push_addr(32'h1234_5678, 0);
        push_addr(32'h1234_5679, 0);
        push_addr(32'h1234_5678, 0);
      end
      for (int k = 0; k < PHASE_REQS; k++) begin
        if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        if (ph == 4 && k == 80) push_drain();
        push_addr(shaped_addr(ob, ib, nw, tag_base),
                  calm ? 0 : (($urandom_range(0, 2) == 0) ? idle_len() : 0));
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || s_tvalid || cfg_valid || lookup_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit.
  always @(posedge clk) begin
    cyc++;
    if (cyc >= CYC_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Request driver: works through the queue one entry at a time.
  always @(negedge clk) begin : drive
    logic nv, ncv;
    logic [31:0] nd;
    logic [salru_pkg::CFG_IDX_W-1:0] nidx;
    logic [salru_pkg::CFG_DATA_W-1:0] ndat;
    req_t cur;
    nv   = s_tvalid;
    nd   = s_tdata;
    ncv  = cfg_valid;
    nidx = cfg_index;
    ndat = cfg_data;
    if (!rst) begin
      // Retire whatever was taken at the last rising edge.
      if (s_tvalid && s_took) begin
        nv = 1'b0;
        void'(req_q.pop_front());
      end
      if (cfg_valid && cfg_took) begin
        ncv = 1'b0;
        void'(req_q.pop_front());
      end
      if (!nv && !ncv && req_q.size() != 0) begin
        cur = req_q[0];
        case (cur.kind)
          OP_ADDR: begin
            if (!gap_armed) begin
              gap_left  = cur.gap;
              gap_armed = 1;
            end
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              gap_armed = 0;
              nv = 1'b1;
              nd = cur.addr;
            end
          end
          OP_CFG: begin
            ncv  = 1'b1;
            nidx = cur.idx;
            ndat = cur.val;
          end
          default: begin
            // Wait for every outstanding result, then let the engine settle.
            if (lookup_q.size() == 0) begin
              if (!settle_armed) begin
                settle_left  = SETTLE_CYC;
                settle_armed = 1;
              end
              if (settle_left > 0) begin
                settle_left--;
              end else begin
                settle_armed = 0;
                void'(req_q.pop_front());
              end
            end
          end
        endcase
      end
    end
    s_tvalid  <= nv;
    s_tdata   <= nd;
    cfg_valid <= ncv;
    cfg_index <= nidx;
    cfg_data  <= ndat;
  end

  // Result receiver: random stalls, calm stretches and one long hold-off.
  always @(negedge clk) begin : receive
    logic rdy;
    rdy = 1'b1;
    if (mode_left == 0) begin
      rx_calm   = ($urandom_range(0, 3) == 0);
      mode_left = $urandom_range(32, 128);
    end else begin
      mode_left--;
    end
    if (rst) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
      hold_left      = LONG_HOLD;
      long_hold_done = 1;
      rdy            = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!rx_calm && $urandom_range(0, 2) == 0) begin
      stall_left = idle_len() - 1;
      rdy        = 1'b0;
    end
    m_tready <= rdy;
  end

  // Checker: results first, then settings, then new predictions.
  always @(posedge clk) begin : check
    salru_pkg::result_t got, want;
    if (rst) begin
      s_took   <= 1'b0;
      cfg_took <= 1'b0;
    end else begin
      s_took   <= s_tvalid && s_tready;
      cfg_took <= cfg_valid && cfg_ready;
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = m_tdata[salru_pkg::RES_W-1:0];
        if (lookup_q.size() == 0) begin
          report_mismatch("result with none expected, tag", got.line_tag, '0);
        end else begin
          want = lookup_q.pop_front();
          if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
          if (got.way !== want.way) report_mismatch("way", 32'(got.way), 32'(want.way));
          if (got.set_index !== want.set_index)
            report_mismatch("set_index", 32'(got.set_index), 32'(want.set_index));
          if (got.line_tag !== want.line_tag)
            report_mismatch("line_tag", got.line_tag, want.line_tag);
          if (got.misses !== want.misses) report_mismatch("misses", got.misses, want.misses);
          if (got.accesses !== want.accesses)
            report_mismatch("accesses", got.accesses, want.accesses);
        end
        if (m_tdata[salru_pkg::RES_BYTES_W-1:salru_pkg::RES_W] !== '0)
          report_mismatch("fill bits",
                          32'(m_tdata[salru_pkg::RES_BYTES_W-1:salru_pkg::RES_W]), '0);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          salru_pkg::REG_OFFSET_BITS: used_offset_bits = cfg_data;
          salru_pkg::REG_INDEX_BITS:  used_index_bits  = cfg_data;
          salru_pkg::REG_WAYS_USED:   used_ways        = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) lookup_q.push_back(lru_lookup(s_tdata));
    end
  end

endmodule

>>> filelist.f
hw/rtl/salru_pkg.sv
hw/rtl/set_assoc_cache_lru_tags.sv
hw/rtl/salru_checker.sv
tb/tb_set_assoc_cache_lru_tags.sv
